FILE: hw/rtl/huffman_tree_decoder_top_defines.svh
// Assertion macros for the Huffman tree decoder.
// They expect signals named clock and reset in the module that uses them.
`ifndef HUFFMAN_TREE_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_TOP_DEFINES_SVH

`define HTD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define HTD_ASSERT_ALWAYS(label, cond, msg) \
   `HTD_ASSERT_IMPLY(label, 1'b1, cond, msg)

`endif

FILE: hw/rtl/htd_pkg.sv
package htd_pkg;

   localparam int CODE_W           = 64;
   localparam int LEN_W            = 7;
   localparam int CNT_W            = 4;
   localparam int BYTE_W           = 8;
   localparam int SYM_W            = 8;
   localparam int DEF_NODES        = 512;
   localparam int DEF_MAX_CODE_LEN = 64;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_SYMBOL  = 2'd0,
      STATUS_LOAD_OK = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_ERROR   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_STEP,
      ST_LOAD_LINK,
      ST_LOAD_FETCH,
      ST_DEC_FETCH,
      ST_DEC_STEP,
      ST_DEC_CHECK,
      ST_DEC_ERROR,
      ST_DEC_FLUSH
   } state_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [SYM_W-1:0]  symbol;
      logic              last;
   } post_type;

endpackage

FILE: hw/rtl/htd_ram.sv
module htd_ram #(
   parameter int WIDTH = 2 * $clog2(htd_pkg::DEF_NODES) + htd_pkg::SYM_W,
   parameter int DEPTH = htd_pkg::DEF_NODES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/htd_seq.sv
`include "huffman_tree_decoder_top_defines.svh"

module htd_seq #(
   parameter int NODES        = htd_pkg::DEF_NODES,
   parameter int MAX_CODE_LEN = htd_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [htd_pkg::SYM_W-1:0]             req_symbol,
   input  logic [htd_pkg::LEN_W-1:0]             req_code_length,
   input  logic [htd_pkg::CODE_W-1:0]            req_code_bits,
   input  logic [htd_pkg::BYTE_W-1:0]            req_data_byte,
   input  logic [htd_pkg::CNT_W-1:0]             req_bit_count,
   input  logic                                  out_free,
   output htd_pkg::post_type                     post,
   output logic                                  mem_we,
   output logic [$clog2(NODES)-1:0]              mem_waddr,
   output logic [2*$clog2(NODES)+htd_pkg::SYM_W-1:0] mem_wdata,
   output logic                                  mem_re,
   output logic [$clog2(NODES)-1:0]              mem_raddr,
   input  logic [2*$clog2(NODES)+htd_pkg::SYM_W-1:0] mem_rdata
);

   localparam int AW      = $clog2(NODES);
   localparam int NU_W    = $clog2(NODES + 1);
   localparam int SYM_W   = htd_pkg::SYM_W;
   localparam int LEN_W   = htd_pkg::LEN_W;
   localparam int BYTE_W  = htd_pkg::BYTE_W;
   localparam int CODE_IW = $clog2(htd_pkg::CODE_W);

   htd_pkg::state_type state_ff, state_in;
   logic [LEN_W-1:0]          rem_ff, rem_in;
   logic [htd_pkg::CODE_W-1:0] code_ff, code_in;
   logic [BYTE_W-1:0]         data_ff, data_in;
   logic [SYM_W-1:0]          symbol_ff, symbol_in;
   logic [AW-1:0]             cur_node_ff, cur_node_in;
   logic [AW-1:0]             cur_left_ff, cur_left_in;
   logic [AW-1:0]             cur_right_ff, cur_right_in;
   logic [SYM_W-1:0]          cur_value_ff, cur_value_in;
   logic [AW-1:0]             root_left_ff, root_left_in;
   logic [AW-1:0]             root_right_ff, root_right_in;
   logic [NU_W-1:0]           nodes_used_ff, nodes_used_in;
   logic [AW-1:0]             walk_ff, walk_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]          pend_symbol_ff, pend_symbol_in;

   logic [LEN_W-1:0]          rem_m1;
   logic                      code_bit;
   logic [AW-1:0]             load_slot;
   logic                      dec_bit;
   logic [AW-1:0]             dec_next;
   logic [AW-1:0]             rd_left;
   logic [AW-1:0]             rd_right;
   logic [SYM_W-1:0]          rd_value;
   logic                      store_full;
   logic [AW-1:0]             new_idx;
   logic [LEN_W-1:0]          len_sat;
   logic [htd_pkg::CNT_W-1:0] cnt_sat;

   assign rem_m1     = rem_ff - LEN_W'(1);
   assign code_bit   = code_ff[rem_m1[CODE_IW-1:0]];
   assign load_slot  = code_bit ? cur_right_ff : cur_left_ff;
   assign dec_bit    = data_ff[BYTE_W-1];
   assign dec_next   = dec_bit ? cur_right_ff : cur_left_ff;
   assign rd_left    = mem_rdata[2*AW+SYM_W-1 -: AW];
   assign rd_right   = mem_rdata[SYM_W +: AW];
   assign rd_value   = mem_rdata[SYM_W-1:0];
   assign store_full = (nodes_used_ff == NU_W'(NODES));
   assign new_idx    = nodes_used_ff[AW-1:0];
   assign len_sat    = (req_code_length > LEN_W'(MAX_CODE_LEN)) ?
                       LEN_W'(MAX_CODE_LEN) : req_code_length;
   assign cnt_sat    = (req_bit_count > htd_pkg::CNT_W'(BYTE_W)) ?
                       htd_pkg::CNT_W'(BYTE_W) : req_bit_count;
   assign req_stall  = (state_ff != htd_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htd_pkg::ST_IDLE;
         rem_ff        <= '0;
         root_left_ff  <= '0;
         root_right_ff <= '0;
         nodes_used_ff <= NU_W'(1);
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rem_ff        <= rem_in;
         root_left_ff  <= root_left_in;
         root_right_ff <= root_right_in;
         nodes_used_ff <= nodes_used_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      data_ff        <= data_in;
      symbol_ff      <= symbol_in;
      cur_node_ff    <= cur_node_in;
      cur_left_ff    <= cur_left_in;
      cur_right_ff   <= cur_right_in;
      cur_value_ff   <= cur_value_in;
      pend_symbol_ff <= pend_symbol_in;
   end

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      code_in        = code_ff;
      data_in        = data_ff;
      symbol_in      = symbol_ff;
      cur_node_in    = cur_node_ff;
      cur_left_in    = cur_left_ff;
      cur_right_in   = cur_right_ff;
      cur_value_in   = cur_value_ff;
      root_left_in   = root_left_ff;
      root_right_in  = root_right_ff;
      nodes_used_in  = nodes_used_ff;
      walk_in        = walk_ff;
      pend_valid_in  = pend_valid_ff;
      pend_symbol_in = pend_symbol_ff;
      post           = '0;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = '0;

      case (state_ff)
         htd_pkg::ST_IDLE: begin
            if (req_valid) begin
               code_in   = req_code_bits;
               data_in   = req_data_byte;
               symbol_in = req_symbol;
               if (req_func == htd_pkg::FUNC_LOAD) begin
                  rem_in       = len_sat;
                  cur_node_in  = '0;
                  cur_left_in  = root_left_ff;
                  cur_right_in = root_right_ff;
                  cur_value_in = '0;
                  state_in     = htd_pkg::ST_LOAD_STEP;
               end else begin
                  rem_in        = LEN_W'(cnt_sat);
                  pend_valid_in = 1'b0;
                  cur_node_in   = walk_ff;
                  if (walk_ff == '0) begin
                     cur_left_in  = root_left_ff;
                     cur_right_in = root_right_ff;
                     cur_value_in = '0;
                     state_in     = htd_pkg::ST_DEC_STEP;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = walk_ff;
                     state_in  = htd_pkg::ST_DEC_FETCH;
                  end
               end
            end
         end

         htd_pkg::ST_LOAD_STEP: begin
            if (rem_ff == '0) begin
               if (out_free) begin
                  post.valid  = 1'b1;
                  post.status = htd_pkg::STATUS_LOAD_OK;
                  post.last   = 1'b1;
                  if (cur_node_ff != '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = cur_node_ff;
                     mem_wdata = {cur_left_ff, cur_right_ff, symbol_ff};
                  end
                  state_in = htd_pkg::ST_IDLE;
               end
            end else if (load_slot != '0) begin
               mem_re      = 1'b1;
               mem_raddr   = load_slot;
               cur_node_in = load_slot;
               rem_in      = rem_m1;
               state_in    = htd_pkg::ST_LOAD_FETCH;
            end else if (store_full) begin
               if (out_free) begin
                  post.valid  = 1'b1;
                  post.status = htd_pkg::STATUS_FULL;
                  post.last   = 1'b1;
                  state_in    = htd_pkg::ST_IDLE;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = new_idx;
               mem_wdata = '0;
               state_in  = htd_pkg::ST_LOAD_LINK;
            end
         end

         htd_pkg::ST_LOAD_LINK: begin
            if (cur_node_ff == '0) begin
               if (code_bit) begin
                  root_right_in = new_idx;
               end else begin
                  root_left_in = new_idx;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = cur_node_ff;
               mem_wdata = code_bit ? {cur_left_ff, new_idx, cur_value_ff}
                                    : {new_idx, cur_right_ff, cur_value_ff};
            end
            cur_node_in   = new_idx;
            cur_left_in   = '0;
            cur_right_in  = '0;
            cur_value_in  = '0;
            nodes_used_in = nodes_used_ff + NU_W'(1);
            rem_in        = rem_m1;
            state_in      = htd_pkg::ST_LOAD_STEP;
         end

         htd_pkg::ST_LOAD_FETCH: begin
            cur_left_in  = rd_left;
            cur_right_in = rd_right;
            cur_value_in = rd_value;
            state_in     = htd_pkg::ST_LOAD_STEP;
         end

         htd_pkg::ST_DEC_FETCH: begin
            cur_left_in  = rd_left;
            cur_right_in = rd_right;
            cur_value_in = rd_value;
            state_in     = htd_pkg::ST_DEC_STEP;
         end

         htd_pkg::ST_DEC_STEP: begin
            if (rem_ff == '0) begin
               state_in = htd_pkg::ST_DEC_FLUSH;
            end else if (dec_next == '0) begin
               walk_in  = '0;
               state_in = htd_pkg::ST_DEC_ERROR;
            end else begin
               mem_re      = 1'b1;
               mem_raddr   = dec_next;
               cur_node_in = dec_next;
               data_in     = {data_ff[BYTE_W-2:0], 1'b0};
               rem_in      = rem_m1;
               state_in    = htd_pkg::ST_DEC_CHECK;
            end
         end

         htd_pkg::ST_DEC_CHECK: begin
            if ((rd_left == '0) && (rd_right == '0)) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     post.valid  = 1'b1;
                     post.status = htd_pkg::STATUS_SYMBOL;
                     post.symbol = pend_symbol_ff;
                     post.last   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_symbol_in = rd_value;
                  walk_in        = '0;
                  cur_node_in    = '0;
                  cur_left_in    = root_left_ff;
                  cur_right_in   = root_right_ff;
                  cur_value_in   = '0;
                  state_in       = htd_pkg::ST_DEC_STEP;
               end
            end else begin
               walk_in      = cur_node_ff;
               cur_left_in  = rd_left;
               cur_right_in = rd_right;
               cur_value_in = rd_value;
               state_in     = htd_pkg::ST_DEC_STEP;
            end
         end

         htd_pkg::ST_DEC_ERROR: begin
            if (out_free) begin
               post.valid = 1'b1;
               if (pend_valid_ff) begin
                  post.status   = htd_pkg::STATUS_SYMBOL;
                  post.symbol   = pend_symbol_ff;
                  post.last     = 1'b0;
                  pend_valid_in = 1'b0;
               end else begin
                  post.status = htd_pkg::STATUS_ERROR;
                  post.last   = 1'b1;
                  state_in    = htd_pkg::ST_IDLE;
               end
            end
         end

         htd_pkg::ST_DEC_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = htd_pkg::ST_IDLE;
            end else if (out_free) begin
               post.valid    = 1'b1;
               post.status   = htd_pkg::STATUS_SYMBOL;
               post.symbol   = pend_symbol_ff;
               post.last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = htd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = htd_pkg::ST_IDLE;
         end
      endcase
   end

   `HTD_ASSERT_ALWAYS(a_nodes_bound, nodes_used_ff <= NU_W'(NODES), "node count beyond store")
   `HTD_ASSERT_ALWAYS(a_walk_alloc, NU_W'(walk_ff) < nodes_used_ff, "walk node not allocated")
   `HTD_ASSERT_IMPLY(a_post_free, post.valid, out_free, "result posted into a full register")
   `HTD_ASSERT_IMPLY(a_rw_apart, mem_we && mem_re, mem_waddr != mem_raddr, "read and write collide")

endmodule

FILE: hw/rtl/huffman_tree_decoder_top.sv
// Huffman tree decoder. A load request (func 0) adds one code to the node store and answers
// with one result, load ok or store full; a decode request (func 1) walks the tree one bit
// at a time and answers with zero to eight results, the final one flagged by last. Each tree
// step reads a node through the registered read port of the node memory, which has separate
// read and write ports; a decode that resumes below the root first fetches that node, and a
// result stall holds the sequencer. The input stalls for the whole of a request. No clearing
// pass follows reset: nodes are allocated in order and each is written when allocated, so
// the block is ready at once.
module huffman_tree_decoder_top #(
   parameter int NODES        = htd_pkg::DEF_NODES,
   parameter int MAX_CODE_LEN = htd_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [htd_pkg::SYM_W-1:0]    req_symbol,
   input  logic [htd_pkg::LEN_W-1:0]    req_code_length,
   input  logic [htd_pkg::CODE_W-1:0]   req_code_bits,
   input  logic [htd_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [htd_pkg::CNT_W-1:0]    req_bit_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [htd_pkg::SYM_W-1:0]    rsp_out_symbol,
   output logic                         rsp_last
);

   localparam int AW      = $clog2(NODES);
   localparam int ENTRY_W = 2 * AW + htd_pkg::SYM_W;

   htd_pkg::post_type           post;
   logic                        out_free;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [ENTRY_W-1:0]          mem_wdata;
   logic                        mem_re;
   logic [AW-1:0]               mem_raddr;
   logic [ENTRY_W-1:0]          mem_rdata;

   logic                        rsp_valid_ff, rsp_valid_in;
   htd_pkg::status_type         rsp_status_ff;
   logic [htd_pkg::SYM_W-1:0]   rsp_symbol_ff;
   logic                        rsp_last_ff;

   htd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   htd_seq #(
      .NODES        (NODES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .req_code_bits   (req_code_bits),
      .req_data_byte   (req_data_byte),
      .req_bit_count   (req_bit_count),
      .out_free        (out_free),
      .post            (post),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = post.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (post.valid) begin
         rsp_status_ff <= post.status;
         rsp_symbol_ff <= post.symbol;
         rsp_last_ff   <= post.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_symbol = rsp_symbol_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
